// ===== rtl/tsap_pkg.sv =====
`default_nettype none

package tsap_pkg;

    // Register indexes, as laid out on the configuration port (8 bytes apart)
    localparam logic [2:0] REG_RULE_COUNT = 3'd0;
    localparam logic [2:0] REG_RULE_WORD0 = 3'd1;

    // Rule modes
    localparam logic [1:0] MODE_CENTER = 2'd0;
    localparam logic [1:0] MODE_VERTEX = 2'd1;
    localparam logic [1:0] MODE_FIXED  = 2'd2;

    // Fields of a rule word
    localparam int MODE_LSB = 0;
    localparam int SPAN_LSB = 2;
    localparam int MULT_LSB = 16;
    localparam int ORGX_LSB = 32;
    localparam int ORGY_LSB = 48;

    // After rule lookup: what to do, the operands and the pass-through values
    typedef struct packed {
        logic               found;
        logic [1:0]         idx;
        logic               stale;
        logic               scale_pt;
        logic               scale_r;
        logic [15:0]        mult;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic [14:0]        r;
    } sel_t;

    // After the multipliers
    typedef struct packed {
        logic               found;
        logic [1:0]         idx;
        logic               stale;
        logic               scale_pt;
        logic               scale_r;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic [14:0]        r;
        logic signed [33:0] prod_x;
        logic signed [33:0] prod_y;
        logic [30:0]        prod_r;
    } prod_t;

endpackage

`default_nettype wire

// ===== rtl/tsap_select.sv =====
`default_nettype none

module tsap_select #(
    parameter int MAX_RULES = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [2:0]         rule_count,
    input  wire logic [63:0]        rule_word [MAX_RULES],
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [31:0]        frame_count,
    input  wire logic               is_circle,
    input  wire logic signed [15:0] point_x,
    input  wire logic signed [15:0] point_y,
    input  wire logic [14:0]        radius,
    input  wire logic signed [15:0] vertex_x,
    input  wire logic signed [15:0] vertex_y,
    input  wire logic signed [15:0] ctr_x,
    input  wire logic signed [15:0] ctr_y,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tsap_pkg::sel_t          out_data
);

    localparam logic [2:0] MAX_N = 3'(MAX_RULES);

    logic           valid_reg;
    tsap_pkg::sel_t data_reg;
    tsap_pkg::sel_t data_next;

    logic [2:0]  n_used;
    logic        hit;
    logic [1:0]  hit_idx;
    logic [63:0] word;
    logic [15:0] total;
    logic [13:0] span;
    logic [1:0]  mode;

    assign n_used = (rule_count > MAX_N) ? MAX_N : rule_count;

    // First rule whose span is forever or whose running sum passes the frame
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = 2'd0;
        word    = '0;
        total   = '0;
        span    = '0;
        for (int i = 0; i < MAX_RULES; i++)
        begin
            if (!hit && (3'(i) < n_used))
            begin
                span  = rule_word[i][tsap_pkg::SPAN_LSB +: 14];
                total = total + {2'b00, span};
                if ((span == 14'd0) || ({16'd0, total} > frame_count))
                begin
                    hit     = 1'b1;
                    hit_idx = 2'(i);
                    word    = rule_word[i];
                end
            end
        end
    end

    assign mode = word[tsap_pkg::MODE_LSB +: 2];

    always_comb
    begin
        data_next          = '0;
        data_next.found    = hit;
        data_next.idx      = hit_idx;
        data_next.mult     = word[tsap_pkg::MULT_LSB +: 16];
        data_next.px       = point_x;
        data_next.py       = point_y;
        data_next.r        = radius;
        data_next.ox       = ctr_x;
        data_next.oy       = ctr_y;
        data_next.stale    = hit && ((mode == tsap_pkg::MODE_VERTEX) ||
                                     (mode == tsap_pkg::MODE_FIXED));
        if (hit)
        begin
            if (mode == tsap_pkg::MODE_FIXED)
            begin
                data_next.scale_pt = 1'b1;
                data_next.scale_r  = is_circle;
                data_next.ox       = word[tsap_pkg::ORGX_LSB +: 16];
                data_next.oy       = word[tsap_pkg::ORGY_LSB +: 16];
            end
            else if (mode == tsap_pkg::MODE_VERTEX)
            begin
                // a circle keeps everything in vertex mode
                data_next.scale_pt = !is_circle;
                data_next.ox       = vertex_x;
                data_next.oy       = vertex_y;
            end
            else
            begin
                data_next.scale_pt = !is_circle;
                data_next.scale_r  = is_circle;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tsap_mult.sv =====
`default_nettype none

module tsap_mult (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire tsap_pkg::sel_t in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output tsap_pkg::prod_t out_data
);

    logic             valid_reg;
    tsap_pkg::prod_t  data_reg;
    tsap_pkg::prod_t  data_next;

    logic signed [16:0] rel_x;
    logic signed [16:0] rel_y;
    logic signed [16:0] mult_s;

    assign rel_x  = 17'(in_data.px) - 17'(in_data.ox);
    assign rel_y  = 17'(in_data.py) - 17'(in_data.oy);
    assign mult_s = $signed({1'b0, in_data.mult});

    always_comb
    begin
        data_next          = '0;
        data_next.found    = in_data.found;
        data_next.idx      = in_data.idx;
        data_next.stale    = in_data.stale;
        data_next.scale_pt = in_data.scale_pt;
        data_next.scale_r  = in_data.scale_r;
        data_next.px       = in_data.px;
        data_next.py       = in_data.py;
        data_next.ox       = in_data.ox;
        data_next.oy       = in_data.oy;
        data_next.r        = in_data.r;
        data_next.prod_x   = rel_x * mult_s;
        data_next.prod_y   = rel_y * mult_s;
        data_next.prod_r   = 31'(in_data.r) * 31'(in_data.mult);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tsap_round.sv =====
`default_nettype none

module tsap_round #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire tsap_pkg::prod_t in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      new_x,
    output logic [15:0]      new_y,
    output logic [14:0]      new_radius,
    output logic             rule_found,
    output logic [1:0]       rule_index,
    output logic             center_stale
);

    localparam logic [34:0] LOW_MASK = (35'd1 <<< FRAC_BITS) - 35'd1;

    // Add the origin back, truncate toward zero, clamp to 16 bits signed
    function automatic logic signed [15:0] finish(input logic signed [33:0] prod,
                                                  input logic signed [15:0] org);
        logic signed [34:0] s;
        logic signed [34:0] q;
        s = 35'(prod) + (35'(org) <<< FRAC_BITS);
        q = s >>> FRAC_BITS;
        if (s[34] && ((s & LOW_MASK) != 35'd0))
        begin
            q = q + 35'sd1;
        end
        if (q > 35'sd32767)
        begin
            return 16'sh7fff;
        end
        else if (q < -35'sd32768)
        begin
            return 16'sh8000;
        end
        return q[15:0];
    endfunction

    logic        valid_reg;
    logic [15:0] x_reg;
    logic [15:0] y_reg;
    logic [14:0] r_reg;
    logic        found_reg;
    logic [1:0]  idx_reg;
    logic        stale_reg;

    logic [15:0] x_next;
    logic [15:0] y_next;
    logic [14:0] r_next;
    logic [30:0] r_shift;

    assign r_shift = in_data.prod_r >> FRAC_BITS;

    always_comb
    begin
        x_next = in_data.px;
        y_next = in_data.py;
        r_next = in_data.r;
        if (in_data.scale_pt)
        begin
            x_next = finish(in_data.prod_x, in_data.ox);
            y_next = finish(in_data.prod_y, in_data.oy);
        end
        if (in_data.scale_r)
        begin
            r_next = (r_shift > 31'd32767) ? 15'h7fff : r_shift[14:0];
        end
    end

    assign in_ready     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign new_x        = x_reg;
    assign new_y        = y_reg;
    assign new_radius   = r_reg;
    assign rule_found   = found_reg;
    assign rule_index   = idx_reg;
    assign center_stale = stale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            r_reg     <= r_next;
            found_reg <= in_data.found;
            idx_reg   <= in_data.idx;
            stale_reg <= in_data.stale;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/timed_scale_about_point.sv =====
// Channel   Direction  Bus                      Word
// s_*       in         tdata 144b, tuser 1b     one point with frame, anchors, radius
// m_*       out        tdata 48b,  tuser 4b     scaled point and radius, rule status
// apb       in/out     paddr 6b, 64b data       rule_count and four rule words
//
// One word a cycle while m_tready keeps the output moving.
// Stages: rule lookup, subtract and multiply, origin add with rounding and clamp.
// rst_n clears the stage valid bits and all configuration registers at once.
// Each stage takes a new word when empty or when the next stage takes its own,
// so a stall at m_tready backs up stage by stage and drops nothing.
`default_nettype none

module timed_scale_about_point #(
    parameter int MAX_RULES = 4,
    parameter int FRAC_BITS = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // frame_count[31:0] point_x[47:32] point_y[63:48] radius[78:64]
    // vertex_x[94:79] vertex_y[110:95] ctr_x[126:111] ctr_y[142:127], pad
    input  wire logic [143:0] s_tdata,
    // is_circle[0]
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // new_x[15:0] new_y[31:16] new_radius[46:32], pad[47]
    output logic [47:0]       m_tdata,
    // rule_found[0] rule_index[2:1] center_stale[3]
    output logic [3:0]        m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    logic [2:0]  rule_count_reg;
    logic [63:0] rule_word_reg [MAX_RULES];
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg <= '0;
            for (int i = 0; i < MAX_RULES; i++)
            begin
                rule_word_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            if (reg_idx == tsap_pkg::REG_RULE_COUNT)
            begin
                rule_count_reg <= pwdata[2:0];
            end
            for (int i = 0; i < MAX_RULES; i++)
            begin
                if (reg_idx == tsap_pkg::REG_RULE_WORD0 + 3'(i))
                begin
                    rule_word_reg[i] <= pwdata;
                end
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == tsap_pkg::REG_RULE_COUNT)
        begin
            prdata = {61'd0, rule_count_reg};
        end
        for (int i = 0; i < MAX_RULES; i++)
        begin
            if (reg_idx == tsap_pkg::REG_RULE_WORD0 + 3'(i))
            begin
                prdata = rule_word_reg[i];
            end
        end
    end

    logic            sel_valid;
    logic            sel_ready;
    tsap_pkg::sel_t  sel_data;
    logic            prod_valid;
    logic            prod_ready;
    tsap_pkg::prod_t prod_data;

    logic [15:0] new_x;
    logic [15:0] new_y;
    logic [14:0] new_radius;
    logic        rule_found;
    logic [1:0]  rule_index;
    logic        center_stale;

    tsap_select #(
        .MAX_RULES (MAX_RULES)
    ) u_select (
        .clk         (clk),
        .rst_n       (rst_n),
        .rule_count  (rule_count_reg),
        .rule_word   (rule_word_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .frame_count (s_tdata[31:0]),
        .is_circle   (s_tuser[0]),
        .point_x     (s_tdata[47:32]),
        .point_y     (s_tdata[63:48]),
        .radius      (s_tdata[78:64]),
        .vertex_x    (s_tdata[94:79]),
        .vertex_y    (s_tdata[110:95]),
        .ctr_x       (s_tdata[126:111]),
        .ctr_y       (s_tdata[142:127]),
        .out_valid   (sel_valid),
        .out_ready   (sel_ready),
        .out_data    (sel_data)
    );

    tsap_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sel_valid),
        .in_ready  (sel_ready),
        .in_data   (sel_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    tsap_round #(
        .FRAC_BITS (FRAC_BITS)
    ) u_round (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (prod_valid),
        .in_ready     (prod_ready),
        .in_data      (prod_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .new_x        (new_x),
        .new_y        (new_y),
        .new_radius   (new_radius),
        .rule_found   (rule_found),
        .rule_index   (rule_index),
        .center_stale (center_stale)
    );

    assign m_tdata = {1'b0, new_radius, new_y, new_x};
    assign m_tuser = {center_stale, rule_index, rule_found};

endmodule

`default_nettype wire

// ===== rtl/tsap_checker.sv =====
`default_nettype none

module tsap_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [3:0]  m_tuser,
    input wire logic        psel,
    input wire logic        pwrite,
    input wire logic [5:0]  paddr,
    input wire logic [63:0] prdata
);

    // hold a word that has not been taken
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // an empty or draining output lets the whole pipeline advance
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("s_tready low with output free");

    a_passthrough_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tuser[3:1] == 3'd0))
        else $error("rule status set without a rule");

    a_count_read: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && (paddr[5:3] == tsap_pkg::REG_RULE_COUNT) |->
            (prdata[63:3] == 61'd0))
        else $error("rule_count read carries stray bits");

endmodule

bind timed_scale_about_point tsap_checker u_tsap_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .prdata   (prdata)
);

`default_nettype wire

// ===== tb/tsap_result_checker.sv =====
`timescale 1ns / 1ps

module tsap_result_checker #(
    parameter int MAX_RULES = 4,
    parameter int FRAC_BITS = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [143:0] s_tdata,
    input  wire logic [0:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [47:0]  m_tdata,
    input  wire logic [3:0]   m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    input  wire logic         pready,
    output int                mismatches,
    output int                outstanding
);

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        r;
        logic               found;
        logic [1:0]         idx;
        logic               stale;
    } scaled_t;

    // Mirror of the rule table, updated from observed register writes
    logic [2:0]  rules_in_use;
    logic [63:0] rule_tbl [4];
    scaled_t     expected_scaled [$];
    int          errs;
    logic [2:0]  widx;
    scaled_t     want;
    scaled_t     got;

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // (p - o) * m / 2^F + o, truncated toward zero
    function automatic logic signed [15:0] scale_coord(input logic signed [15:0] p,
                                                       input logic signed [15:0] o,
                                                       input logic [15:0] m);
        longint acc;
        acc = (longint'(p) - longint'(o)) * longint'(m)
              + longint'(o) * (longint'(1) << FRAC_BITS);
        return clamp16(acc / (longint'(1) << FRAC_BITS));
    endfunction

    function automatic logic [14:0] scale_len(input logic [14:0] r, input logic [15:0] m);
        longint v;
        v = (longint'(r) * longint'(m)) >> FRAC_BITS;
        return (v > 32767) ? 15'h7FFF : v[14:0];
    endfunction

    function automatic scaled_t scaled_point(input logic [143:0] d, input logic circle);
        logic [31:0]        frame;
        logic signed [15:0] px, py, vx, vy, cx, cy, ox, oy;
        logic [14:0]        r;
        logic [13:0]        span;
        logic [63:0]        w;
        logic [1:0]         mode;
        logic [15:0]        m;
        longint             total;
        int                 n;
        int                 sel;
        logic               hit;
        scaled_t            res;
        frame = d[31:0];
        px = d[47:32];
        py = d[63:48];
        r  = d[78:64];
        vx = d[94:79];
        vy = d[110:95];
        cx = d[126:111];
        cy = d[142:127];
        n = (rules_in_use > MAX_RULES) ? MAX_RULES : int'(rules_in_use);
        total = 0;
        hit = 1'b0;
        sel = 0;
        for (int i = 0; i < MAX_RULES; i++)
        begin
            if (!hit && i < n)
            begin
                span = rule_tbl[i][tsap_pkg::SPAN_LSB +: 14];
                total += longint'(span);
                // a zero span holds forever
                if (span == 0 || total > longint'(frame))
                begin
                    hit = 1'b1;
                    sel = i;
                end
            end
        end
        res.x = px;
        res.y = py;
        res.r = r;
        res.found = hit;
        res.idx = hit ? sel[1:0] : 2'd0;
        res.stale = 1'b0;
        if (hit)
        begin
            w = rule_tbl[sel];
            mode = w[tsap_pkg::MODE_LSB +: 2];
            m = w[tsap_pkg::MULT_LSB +: 16];
            ox = w[tsap_pkg::ORGX_LSB +: 16];
            oy = w[tsap_pkg::ORGY_LSB +: 16];
            if (circle)
            begin
                // circle: fixed moves centre and radius, vertex leaves it alone, other modes scale the radius only
                if (mode == tsap_pkg::MODE_FIXED)
                begin
                    res.x = scale_coord(px, ox, m);
                    res.y = scale_coord(py, oy, m);
                    res.r = scale_len(r, m);
                end
                else if (mode != tsap_pkg::MODE_VERTEX)
                begin
                    res.r = scale_len(r, m);
                end
            end
            else if (mode == tsap_pkg::MODE_FIXED)
            begin
                res.x = scale_coord(px, ox, m);
                res.y = scale_coord(py, oy, m);
            end
            else if (mode == tsap_pkg::MODE_VERTEX)
            begin
                res.x = scale_coord(px, vx, m);
                res.y = scale_coord(py, vy, m);
            end
            else
            begin
                res.x = scale_coord(px, cx, m);
                res.y = scale_coord(py, cy, m);
            end
            res.stale = (mode == tsap_pkg::MODE_VERTEX) || (mode == tsap_pkg::MODE_FIXED);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rules_in_use = '0;
            for (int i = 0; i < 4; i++)
                rule_tbl[i] = '0;
            expected_scaled.delete();
            errs = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                widx = paddr[5:3];
                if (widx == tsap_pkg::REG_RULE_COUNT)
                    rules_in_use = pwdata[2:0];
                else if (widx >= tsap_pkg::REG_RULE_WORD0 &&
                         widx < tsap_pkg::REG_RULE_WORD0 + 3'd4)
                    rule_tbl[widx - tsap_pkg::REG_RULE_WORD0] = pwdata;
            end
            if (s_tvalid && s_tready)
                expected_scaled.insert(expected_scaled.size(),
                                       scaled_point(s_tdata, s_tuser[0]));
            if (m_tvalid && m_tready)
            begin
                got.x = m_tdata[15:0];
                got.y = m_tdata[31:16];
                got.r = m_tdata[46:32];
                got.found = m_tuser[0];
                got.idx = m_tuser[2:1];
                got.stale = m_tuser[3];
                if (expected_scaled.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected word: x=%0d y=%0d r=%0d found=%b idx=%0d stale=%b",
                                 got.x, got.y, got.r, got.found, got.idx, got.stale);
                end
                else
                begin
                    want = expected_scaled.pop_front();
                    if (got !== want)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display({"mismatch: expected x=%0d y=%0d r=%0d found=%b idx=%0d ",
                                      "stale=%b, got x=%0d y=%0d r=%0d found=%b idx=%0d stale=%b"},
                                     want.x, want.y, want.r, want.found, want.idx, want.stale,
                                     got.x, got.y, got.r, got.found, got.idx, got.stale);
                    end
                end
            end
            mismatches <= errs;
            outstanding <= expected_scaled.size();
        end
    end

endmodule

// ===== tb/tb_timed_scale_about_point.sv =====
`timescale 1ns / 1ps

module tb_timed_scale_about_point;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam logic [2:0] REG_UNUSED  = tsap_pkg::REG_RULE_WORD0 + 3'd4;
    localparam int         ITEMS       = 1500;
    localparam int         HOLD_CYCLES = 80;
    localparam int         IDLE_LIMIT  = 2000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // frame_count[31:0] point_x[47:32] point_y[63:48] radius[78:64]
    // vertex_x[94:79] vertex_y[110:95] ctr_x[126:111] ctr_y[142:127], pad
    logic [143:0] s_tdata = '0;
    // is_circle[0]
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // new_x[15:0] new_y[31:16] new_radius[46:32], pad[47]
    logic [47:0]  m_tdata;
    // rule_found[0] rule_index[2:1] center_stale[3]
    logic [3:0]   m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [5:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;

    int           mismatches;
    int           outstanding;
    int           hold_asks = 0;
    int           hold_done = 0;
    int           idle_cycles = 0;
    logic [2:0]   plan_count;
    logic [63:0]  plan [4];
    int           prefix [4];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    timed_scale_about_point u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tsap_result_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    // Any handshake on any port resets the idle count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Output side: ready pattern changes at random intervals; long hold on request
    initial
    begin : drain_side
        int ready_pct;
        int pattern_left;
        ready_pct = 100;
        pattern_left = 0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_done != hold_asks)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_done++;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 80;
                        2: ready_pct = 50;
                        default: ready_pct = 15;
                    endcase
                    pattern_left = $urandom_range(16, 96);
                end
                pattern_left--;
                m_tready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    function automatic logic [63:0] make_rule(input logic [1:0] mode, input logic [13:0] span,
                                              input logic [15:0] mult, input logic [15:0] ox,
                                              input logic [15:0] oy);
        return {oy, ox, mult, span, mode};
    endfunction

    function automatic logic [15:0] any_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3: return 16'($urandom_range(0, 512) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] any_frame();
        int k;
        k = $urandom_range(0, 3);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            2: return 32'd0;
            3, 4: return 32'(prefix[k] - $urandom_range(0, 1));
            default: return $urandom_range(0, prefix[3] + 4);
        endcase
    endfunction

    function automatic logic [63:0] random_rule();
        logic [13:0] span;
        logic [15:0] mult;
        case ($urandom_range(0, 5))
            0: span = 14'd0;
            1: span = 14'h3FFF;
            2: span = 14'($urandom);
            default: span = 14'($urandom_range(1, 24));
        endcase
        case ($urandom_range(0, 6))
            0: mult = 16'h0000;
            1: mult = 16'hFFFF;
            2, 3: mult = 16'(32'h0100 + $urandom_range(0, 64) - 32);
            4: mult = 16'($urandom_range(0, 16'h0400));
            default: mult = 16'($urandom);
        endcase
        return make_rule(2'($urandom_range(0, 3)), span, mult, any_coord(), any_coord());
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_plan();
        int running;
        running = 0;
        write_reg(tsap_pkg::REG_RULE_COUNT, {61'd0, plan_count});
        for (int i = 0; i < 4; i++)
        begin
            write_reg(tsap_pkg::REG_RULE_WORD0 + 3'(i), plan[i]);
            running += int'(plan[i][tsap_pkg::SPAN_LSB +: 14]);
            prefix[i] = running;
        end
    endtask

    task automatic send_point(input logic [31:0] frame, input logic circle,
                              input logic [15:0] px, input logic [15:0] py,
                              input logic [14:0] r, input logic [15:0] vx,
                              input logic [15:0] vy, input logic [15:0] cx,
                              input logic [15:0] cy, input int gap);
        s_tdata <= {1'b0, cy, cx, vy, vx, r, py, px, frame};
        s_tuser <= circle;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    task automatic send_random_point(input int gap);
        logic [14:0] r;
        case ($urandom_range(0, 7))
            0: r = 15'h7FFF;
            1: r = 15'd0;
            default: r = 15'($urandom);
        endcase
        send_point(any_frame(), 1'($urandom), any_coord(), any_coord(), r,
                   any_coord(), any_coord(), any_coord(), any_coord(), gap);
    endtask

    // Drop valid and wait for every word in flight to come out
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int sent;
        int phase;
        int items;
        int burst_left;
        int gap;
        logic calm;
        for (int i = 0; i < 4; i++)
            prefix[i] = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No rules after reset: everything passes through
        send_point(32'd0, 1'b0, 16'h7FFF, 16'h8000, 15'h7FFF, 16'h8000, 16'h7FFF,
                   16'h0000, 16'hFFFF, 0);
        send_point(32'hFFFF_FFFF, 1'b1, 16'h8000, 16'h7FFF, 15'd0, 16'h7FFF, 16'h8000,
                   16'hFFFF, 16'h0000, 2);
        quiesce();

        // One rule per mode, the last one forever
        plan_count = 3'd4;
        plan[0] = make_rule(tsap_pkg::MODE_CENTER, 14'd10, 16'h0200, 16'h0000, 16'h0000);
        plan[1] = make_rule(tsap_pkg::MODE_VERTEX, 14'd5, 16'h0080, 16'h0000, 16'h0000);
        plan[2] = make_rule(tsap_pkg::MODE_FIXED, 14'd3, 16'hFFFF, 16'h8000, 16'h7FFF);
        plan[3] = make_rule(MODE_SPARE, 14'd0, 16'h0180, 16'h1234, 16'h4321);
        load_plan();
        send_point(32'd0, 1'b0, 16'd1000, -16'd2000, 15'd50, -16'd5, 16'd7,
                   16'd100, 16'd100, 0);
        send_point(32'd9, 1'b1, 16'd300, 16'd400, 15'd20000, 16'd1, 16'd2, 16'd3, 16'd4, 0);
        send_point(32'd10, 1'b0, 16'h8000, 16'h7FFF, 15'd9, 16'h7FFF, 16'h8000,
                   16'd0, 16'd0, 1);
        send_point(32'd14, 1'b1, 16'd77, -16'd77, 15'd1234, 16'd5, 16'd5, 16'd0, 16'd0, 0);
        send_point(32'd15, 1'b0, 16'h7FFF, 16'h8000, 15'd0, 16'd0, 16'd0, 16'd0, 16'd0, 0);
        send_point(32'd17, 1'b1, -16'd7, 16'd9, 15'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 3);
        send_point(32'd18, 1'b0, 16'd5, -16'd5, 15'd8, 16'd0, 16'd0, -16'd3, -16'd3, 0);
        send_point(32'hFFFF_FFFF, 1'b1, 16'd11, 16'd22, 15'd1000, 16'd0, 16'd0,
                   16'd0, 16'd0, 0);
        quiesce();

        // Count above the table size, every span used up; stray register write
        plan_count = 3'd7;
        plan[0] = make_rule(tsap_pkg::MODE_FIXED, 14'd1, 16'h0100, 16'd10, -16'd10);
        plan[1] = make_rule(tsap_pkg::MODE_CENTER, 14'd2, 16'h0300, 16'd0, 16'd0);
        plan[2] = make_rule(tsap_pkg::MODE_VERTEX, 14'd3, 16'h0040, 16'd0, 16'd0);
        plan[3] = make_rule(tsap_pkg::MODE_FIXED, 14'd4, 16'h00FF, -16'd500, 16'd500);
        load_plan();
        write_reg(REG_UNUSED, '1);
        send_point(32'd10, 1'b0, 16'd123, 16'd456, 15'd7, 16'd0, 16'd0, 16'd0, 16'd0, 0);
        send_point(32'd9, 1'b0, -16'd123, 16'd456, 15'd7, 16'd0, 16'd0, 16'd0, 16'd0, 0);
        send_point(32'd0, 1'b1, 16'd1, -16'd1, 15'd300, 16'd0, 16'd0, 16'd0, 16'd0, 0);
        quiesce();

        // Zero multiplier: everything collapses onto the origin
        plan_count = 3'd1;
        plan[0] = make_rule(tsap_pkg::MODE_FIXED, 14'd0, 16'h0000, 16'h8001, 16'h7FFF);
        plan[1] = '0;
        plan[2] = '0;
        plan[3] = '0;
        load_plan();
        send_point(32'hFFFF_FFFF, 1'b0, 16'h7FFF, 16'h8000, 15'd1, 16'd0, 16'd0,
                   16'd0, 16'd0, 0);
        send_point(32'd0, 1'b1, 16'h8000, 16'h7FFF, 15'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 0);
        quiesce();

        // Longest span, identity scale
        plan_count = 3'd2;
        plan[0] = make_rule(tsap_pkg::MODE_CENTER, 14'h3FFF, 16'h0100, 16'd0, 16'd0);
        plan[1] = make_rule(tsap_pkg::MODE_VERTEX, 14'd1, 16'h0101, 16'd0, 16'd0);
        load_plan();
        send_point(32'd16382, 1'b0, 16'd999, -16'd999, 15'd3, 16'd0, 16'd0,
                   16'd17, -16'd17, 0);
        send_point(32'd16383, 1'b0, 16'd999, -16'd999, 15'd3, 16'd40, -16'd40,
                   16'd0, 16'd0, 0);
        send_point(32'd16384, 1'b1, 16'd999, -16'd999, 15'd3, 16'd0, 16'd0, 16'd0, 16'd0, 0);
        quiesce();

        sent = 0;
        phase = 0;
        while (sent < ITEMS)
        begin
            case ($urandom_range(0, 7))
                0: plan_count = 3'd0;
                1: plan_count = 3'd7;
                2: plan_count = 3'($urandom_range(5, 6));
                3: plan_count = 3'($urandom_range(1, 3));
                default: plan_count = 3'd4;
            endcase
            for (int i = 0; i < 4; i++)
                plan[i] = random_rule();
            load_plan();
            items = $urandom_range(60, 140);
            calm = (phase == 0) || ($urandom_range(0, 3) == 0);
            // First phase: hold the output off while words keep coming
            if (phase == 0)
                hold_asks++;
            burst_left = 0;
            for (int k = 0; k < items; k++)
            begin
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 32);
                burst_left--;
                gap = (calm || burst_left != 0) ? 0 : $urandom_range(1, 10);
                send_random_point(gap);
            end
            quiesce();
            sent += items;
            phase++;
        end

        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
